FILE: rtl/small_set_table_defines.svh
// assertion helpers used by small_set_table.sv
`ifndef SMALL_SET_TABLE_DEFINES_SVH
`define SMALL_SET_TABLE_DEFINES_SVH

// plain clocked check, off while in reset
`define SST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked in the cycle after the condition
`define SST_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: rtl/sst_pkg.sv
package sst_pkg;

	localparam int CAPACITY = 128;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int NUM_W    = 32;
	localparam int CHR_W    = 8;
	localparam int ACT_W    = 2;
	localparam int TOT_W    = 8;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 16;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [CHR_W-1:0]        chr;
	} ent_t;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic signed [NUM_W-1:0] num;
		logic [CHR_W-1:0]        chr;
	} req_t;

	// token walking the row and the match seen so far
	typedef struct packed {
		logic tok;
		logic found;
	} link_t;

endpackage

FILE: rtl/sst_cell.sv
module sst_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [sst_pkg::IDX_W-1:0] idx,
	input  logic [sst_pkg::CNT_W-1:0] count,
	input  sst_pkg::req_t           req,
	input  sst_pkg::link_t          link_in,
	input  sst_pkg::ent_t           nbr_ent,
	output sst_pkg::link_t          link_out,
	output sst_pkg::ent_t           ent
);

	sst_pkg::ent_t ent_q;
	logic          tok_q;
	logic          found_q;
	logic          live;
	logic          hit;
	logic          do_ins;
	logic          do_shift;

	assign live     = sst_pkg::CNT_W'(idx) < count;
	assign hit      = live && ((ent_q.num == req.num) || (ent_q.chr == req.chr));
	assign do_ins   = link_in.tok && (req.action == sst_pkg::ACT_INSERT)
	                  && (sst_pkg::CNT_W'(idx) == count);
	// once a match is seen at or before this cell, pull the next entry down
	assign do_shift = link_in.tok && (req.action == sst_pkg::ACT_REMOVE)
	                  && live && (link_in.found || hit);

	always_ff @(posedge clk) begin
		if (do_ins) begin
			ent_q.num <= req.num;
			ent_q.chr <= req.chr;
		end else if (do_shift) begin
			ent_q <= nbr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			tok_q   <= link_in.tok;
			found_q <= link_in.tok && (link_in.found || hit);
		end
	end

	assign link_out.tok   = tok_q;
	assign link_out.found = found_q;
	assign ent            = ent_q;

endmodule

FILE: rtl/small_set_table.sv
// Set table of up to CAPACITY entries (number, character), one entry per cell in a row of
// cells. A request is a 2-bit action in s_tuser (clear, insert, lookup, remove first
// match) with the entry in s_tdata. A token walks the cell row one cell per cycle, each cell
// compares itself against the request, and a remove shifts the later entries down as the
// token passes. When the token leaves the row the result is queued, and it moves to the
// output register as soon as that is free; the next request may be accepted while that
// result waits. The input is held off while the token walks the row and while a finished
// result is still queued behind an untaken one.
`include "small_set_table_defines.svh"

module small_set_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_number [31:0], entry_char [39:32]
	input  logic [sst_pkg::IN_W-1:0]      s_tdata,
	// action [1:0]
	input  logic [sst_pkg::ACT_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found [0], full_refused [1], entry_total [9:2], is_empty [10], zero fill above
	output logic [sst_pkg::OUT_W-1:0]     m_tdata
);

	sst_pkg::req_t                 req_q;
	sst_pkg::link_t                link [0:sst_pkg::CAPACITY];
	sst_pkg::ent_t                 ents [0:sst_pkg::CAPACITY-1];
	logic [sst_pkg::CAPACITY-1:0]  tok_vec;
	logic [sst_pkg::CNT_W-1:0]     count_q;
	logic [sst_pkg::CNT_W-1:0]     cnt_nx;
	logic                          busy_q;
	logic                          start_q;
	logic                          pend_q;
	logic [sst_pkg::OUT_W-1:0]     res_q;
	logic [sst_pkg::OUT_W-1:0]     res_w;
	logic                          accept;
	logic                          done;
	logic                          found_w;
	logic                          refused_w;
	logic                          out_free;
	logic                          rm_hit;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign done     = link[sst_pkg::CAPACITY].tok;
	assign out_free = !m_tvalid || m_tready;
	assign rm_hit   = done && (req_q.action == sst_pkg::ACT_REMOVE)
	                  && link[sst_pkg::CAPACITY].found;

	assign link[0].tok   = start_q;
	assign link[0].found = 1'b0;

	for (genvar i = 0; i < sst_pkg::CAPACITY; i++) begin : g_cell
		sst_pkg::ent_t nbr;
		if (i < sst_pkg::CAPACITY - 1) begin : g_mid
			assign nbr = ents[i+1];
		end else begin : g_end
			assign nbr = ents[i];
		end
		sst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (sst_pkg::IDX_W'(i)),
			.count    (count_q),
			.req      (req_q),
			.link_in  (link[i]),
			.nbr_ent  (nbr),
			.link_out (link[i+1]),
			.ent      (ents[i])
		);
		assign tok_vec[i] = link[i+1].tok;
	end

	always_comb begin
		cnt_nx    = count_q;
		found_w   = 1'b0;
		refused_w = 1'b0;
		unique case (req_q.action)
			sst_pkg::ACT_CLEAR: begin
				cnt_nx = '0;
			end
			sst_pkg::ACT_INSERT: begin
				if (count_q < sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
					cnt_nx = count_q + 1'b1;
				end else begin
					refused_w = 1'b1;
				end
			end
			sst_pkg::ACT_LOOKUP: begin
				found_w = link[sst_pkg::CAPACITY].found;
			end
			sst_pkg::ACT_REMOVE: begin
				found_w = link[sst_pkg::CAPACITY].found;
				if (found_w) begin
					cnt_nx = count_q - 1'b1;
				end
			end
			default: begin
				cnt_nx = count_q;
			end
		endcase
		res_w      = '0;
		res_w[0]   = found_w;
		res_w[1]   = refused_w;
		res_w[9:2] = sst_pkg::TOT_W'(cnt_nx);
		res_w[10]  = (cnt_nx == '0);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.action <= s_tuser;
			req_q.num    <= s_tdata[31:0];
			req_q.chr    <= s_tdata[39:32];
		end
		if (done) begin
			res_q <= res_w;
		end
		if (pend_q && out_free) begin
			m_tdata <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			start_q  <= 1'b0;
			pend_q   <= 1'b0;
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (done) begin
				count_q <= cnt_nx;
				pend_q  <= 1'b1;
			end
			if (pend_q && out_free) begin
				pend_q   <= 1'b0;
				busy_q   <= 1'b0;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	`SST_ASSERT(a_count_bound, count_q <= sst_pkg::CNT_W'(sst_pkg::CAPACITY), "count over capacity")
	`SST_ASSERT(a_one_token, $onehot0({tok_vec, start_q}), "more than one token in the row")
	`SST_ASSERT(a_done_free, done |-> (!pend_q && busy_q), "request done with a result pending")
	`SST_ASSERT_NEXT(a_remove_cnt, rm_hit, count_q == $past(count_q) - 1'b1, "remove kept the count")

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 800;

	// one result beat, decoded
	typedef struct packed {
		logic                      found;
		logic                      refused;
		logic [sst_pkg::TOT_W-1:0] total;
		logic                      empty;
	} table_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [sst_pkg::IN_W-1:0]   s_tdata;
	logic [sst_pkg::ACT_W-1:0]  s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [sst_pkg::OUT_W-1:0]  m_tdata;

	sst_pkg::ent_t held_entries[$];
	table_result_t pending_results[$];

	bit idle_enable = 1'b1;
	int hold_cycles = 0;
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int refusals_seen = 0;
	int hits_seen = 0;
	int deepest_fill = 0;

	small_set_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow copy of the table; returns the result the request should give
	function automatic table_result_t apply_to_shadow_table(logic [sst_pkg::ACT_W-1:0] act,
			logic signed [sst_pkg::NUM_W-1:0] num, logic [sst_pkg::CHR_W-1:0] chr);
		table_result_t r;
		sst_pkg::ent_t e;
		int            hit;
		r     = '0;
		hit   = -1;
		e.num = num;
		e.chr = chr;
		for (int i = 0; i < held_entries.size(); i++) begin
			if (hit < 0 && (held_entries[i].num == num || held_entries[i].chr == chr))
				hit = i;
		end
		case (act)
			sst_pkg::ACT_CLEAR: begin
				held_entries.delete();
			end
			sst_pkg::ACT_INSERT: begin
				if (held_entries.size() >= sst_pkg::CAPACITY)
					r.refused = 1'b1;
				else
					held_entries.push_back(e);
			end
			sst_pkg::ACT_LOOKUP: begin
				r.found = (hit >= 0);
			end
			sst_pkg::ACT_REMOVE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					held_entries.delete(hit);
				end
			end
		endcase
		r.total = sst_pkg::TOT_W'(held_entries.size());
		r.empty = (held_entries.size() == 0);
		if (r.refused)
			refusals_seen++;
		if (r.found)
			hits_seen++;
		if (held_entries.size() > deepest_fill)
			deepest_fill = held_entries.size();
		return r;
	endfunction

	// half the values come from a small pool so that matches are common
	function automatic logic signed [sst_pkg::NUM_W-1:0] pick_num();
		case ($urandom_range(0, 15))
			0: return 32'sh0000_0000;
			1: return -32'sd1;
			2: return 32'sd1;
			3: return 32'sh7fff_ffff;
			4: return 32'sh8000_0000;
			5: return 32'sd100;
			6: return 32'sd42;
			7: return 32'sh5555_aaaa;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [sst_pkg::CHR_W-1:0] pick_chr();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hff;
			2: return "a";
			3: return "b";
			4: return "c";
			5: return 8'h55;
			6: return 8'haa;
			7: return 8'd100;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic issue_request(input logic [sst_pkg::ACT_W-1:0] act,
			input logic signed [sst_pkg::NUM_W-1:0] num,
			input logic [sst_pkg::CHR_W-1:0] chr);
		int gap;
		gap = idle_enable ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {chr, num};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_to_shadow_table(act, num, chr));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic check_result(input logic [sst_pkg::OUT_W-1:0] beat);
		table_result_t want;
		if (pending_results.size() == 0) begin
			$error("result beat %h with no request pending", beat);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (beat[0] !== want.found) begin
			$error("found: expected %0d, got %0d", want.found, beat[0]);
			error_count++;
		end
		if (beat[1] !== want.refused) begin
			$error("full_refused: expected %0d, got %0d", want.refused, beat[1]);
			error_count++;
		end
		if (beat[9:2] !== want.total) begin
			$error("entry_total: expected %0d, got %0d", want.total, beat[9:2]);
			error_count++;
		end
		if (beat[10] !== want.empty) begin
			$error("is_empty: expected %0d, got %0d", want.empty, beat[10]);
			error_count++;
		end
	endtask

	// result side: random stalls, or one long hold-off when a test asks for it
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = idle_enable ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result(m_tdata);
			@(negedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("no beat moved for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, pending_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic test_empty_table();
		issue_request(sst_pkg::ACT_LOOKUP, 32'sd0, 8'h00);
		issue_request(sst_pkg::ACT_REMOVE, -32'sd1, 8'hff);
		issue_request(sst_pkg::ACT_CLEAR, 32'sd5, "x");
	endtask

	task automatic test_insert_extremes();
		issue_request(sst_pkg::ACT_INSERT, 32'sh8000_0000, 8'h00);
		issue_request(sst_pkg::ACT_INSERT, 32'sh7fff_ffff, 8'hff);
		issue_request(sst_pkg::ACT_INSERT, 32'sd0, "a");
		issue_request(sst_pkg::ACT_INSERT, -32'sd1, "b");
		// duplicates are allowed
		issue_request(sst_pkg::ACT_INSERT, -32'sd1, "b");
	endtask

	task automatic test_match_rules();
		issue_request(sst_pkg::ACT_LOOKUP, 32'sh7fff_ffff, "z");
		issue_request(sst_pkg::ACT_LOOKUP, 32'sd12345, 8'h00);
		issue_request(sst_pkg::ACT_LOOKUP, 32'sd777, "q");
		// two entries hold -1, only the lower one goes
		issue_request(sst_pkg::ACT_REMOVE, -32'sd1, "x");
		issue_request(sst_pkg::ACT_REMOVE, 32'sd9, 8'h00);
		issue_request(sst_pkg::ACT_LOOKUP, 32'sh8000_0000, "y");
		issue_request(sst_pkg::ACT_REMOVE, 32'sd31337, "q");
		issue_request(sst_pkg::ACT_LOOKUP, -32'sd1, "n");
		issue_request(sst_pkg::ACT_CLEAR, 32'sd0, 8'h00);
	endtask

	task automatic test_full_table();
		sst_pkg::ent_t mid;
		idle_enable = 1'b0;
		issue_request(sst_pkg::ACT_CLEAR, 32'sd0, 8'h00);
		for (int i = 0; i < sst_pkg::CAPACITY; i++)
			issue_request(sst_pkg::ACT_INSERT, pick_num(), pick_chr());
		repeat (3) issue_request(sst_pkg::ACT_INSERT, pick_num(), pick_chr());
		mid = held_entries[sst_pkg::CAPACITY / 2];
		issue_request(sst_pkg::ACT_LOOKUP, mid.num, mid.chr);
		issue_request(sst_pkg::ACT_REMOVE, mid.num, mid.chr);
		issue_request(sst_pkg::ACT_INSERT, 32'sh7fff_ffff, 8'hff);
		issue_request(sst_pkg::ACT_INSERT, 32'sh8000_0000, 8'h00);
		idle_enable = 1'b1;
	endtask

	task automatic test_backpressure();
		idle_enable = 1'b0;
		hold_cycles = HOLD_LEN;
		repeat (12) issue_request(2'($urandom_range(1, 3)), pick_num(), pick_chr());
		idle_enable = 1'b1;
	endtask

	task automatic test_random_mix(input int count, input int insert_pct,
			input int clear_pct, input bit with_idle);
		int                         pick;
		logic [sst_pkg::ACT_W-1:0]  act;
		idle_enable = with_idle;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < clear_pct)
				act = sst_pkg::ACT_CLEAR;
			else if (pick < clear_pct + insert_pct)
				act = sst_pkg::ACT_INSERT;
			else if (pick[0])
				act = sst_pkg::ACT_LOOKUP;
			else
				act = sst_pkg::ACT_REMOVE;
			issue_request(act, pick_num(), pick_chr());
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = sst_pkg::ACT_CLEAR;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_insert_extremes();
		test_match_rules();
		test_full_table();
		test_backpressure();
		test_random_mix(300, 50, 2, 1'b1);
		test_random_mix(200, 85, 0, 1'b0);
		test_random_mix(200, 20, 0, 1'b1);
		test_random_mix(150, 45, 5, 1'b1);
		s_tvalid <= 1'b0;

		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (sst_pkg::CAPACITY + 8) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d inserts refused, %0d matches",
			requests_sent, results_checked, refusals_seen, hits_seen);
		$display("table filled to %0d of %0d entries, %0d mismatches",
			deepest_fill, sst_pkg::CAPACITY, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
